### sv/gnmd_pkg.sv
// package: shared types, codes and constants for the grid move diff block
`timescale 1ns / 1ps
`default_nettype none
package gnmd_pkg;

    localparam int unsigned REACH = 1;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 16;

    typedef enum logic [1:0] {
        CFG_CELL_WIDTH  = 2'd0,
        CFG_CELL_HEIGHT = 2'd1,
        CFG_GRID_ROWS   = 2'd2,
        CFG_GRID_COLS   = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        KIND_LEAVE  = 3'd0,
        KIND_ENTER  = 3'd1,
        KIND_MOVE   = 3'd2,
        KIND_REMOVE = 3'd3,
        KIND_ADD    = 3'd4,
        KIND_DONE   = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_OLD_OFF = 2'd1,
        ST_NEW_OFF = 2'd2
    } t_status;

    typedef struct packed {
        logic [15:0] mover_id;
        logic [15:0] old_x;
        logic [15:0] old_y;
        logic [15:0] new_x;
        logic [15:0] new_y;
    } t_in_beat;

    typedef struct packed {
        logic [15:0] mover_tag;
        logic [2:0]  kind;
        logic [31:0] cell_index;
        logic [1:0]  status;
        logic        last;
    } t_out_beat;

    // classified job handed from front to back
    typedef struct packed {
        logic [15:0] tag;
        t_status     status;
        logic [15:0] orow;
        logic [15:0] ocol;
        logic [15:0] nrow;
        logic [15:0] ncol;
    } t_job;

    // grid configuration seen by both parts
    typedef struct packed {
        logic [15:0] cell_w;
        logic [15:0] cell_h;
        logic [15:0] rows;
        logic [15:0] cols;
    } t_cfg;

endpackage
`default_nettype wire

### sv/gnmd_front.sv
// front: divides positions by cell size and classifies the move
`timescale 1ns / 1ps
`default_nettype none
module gnmd_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  gnmd_pkg::t_cfg       i_cfg,
    input  wire                  i_valid,
    output logic                 o_stall,
    input  gnmd_pkg::t_in_beat   i_data,
    output logic                 o_job_valid,
    input  wire                  i_job_stall,
    output gnmd_pkg::t_job       o_job
);
    import gnmd_pkg::*;

    // four restoring dividers run side by side, one quotient bit per cycle
    logic        r_busy;
    logic [4:0]  r_cnt;
    logic [15:0] r_tag;
    logic [15:0] r_num [4];
    logic [15:0] r_rem [4];
    logic [15:0] r_quo [4];
    logic [15:0] r_div [4];
    logic        r_done;
    t_job        r_job;

    logic [15:0] n_num [4];
    logic [15:0] n_rem [4];
    logic [15:0] n_quo [4];
    logic [16:0] w_trial [4];
    logic [15:0] w_cell [4];
    logic        w_old_off;
    logic        w_new_off;

    assign o_stall = r_busy || (r_done && i_job_stall);
    assign o_job_valid = r_done;
    assign o_job = r_job;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_trial[k] = {r_rem[k], r_num[k][15]} - {1'b0, r_div[k]};
            n_num[k] = {r_num[k][14:0], 1'b0};
            if (!w_trial[k][16]) begin
                n_rem[k] = w_trial[k][15:0];
                n_quo[k] = {r_quo[k][14:0], 1'b1};
            end else begin
                n_rem[k] = {r_rem[k][14:0], r_num[k][15]};
                n_quo[k] = {r_quo[k][14:0], 1'b0};
            end
            // division by zero gives all ones, as does this loop
            w_cell[k] = r_quo[k];
        end
        // order: 0 orow, 1 ocol, 2 nrow, 3 ncol
        w_old_off = (w_cell[0] >= i_cfg.rows) || (w_cell[1] >= i_cfg.cols);
        w_new_off = (w_cell[2] >= i_cfg.rows) || (w_cell[3] >= i_cfg.cols);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (r_done && !i_job_stall) r_done <= 1'b0;
            if (!o_stall && i_valid) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd0;
            end else if (r_busy) begin
                if (r_cnt == 5'd16) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_tag <= i_data.mover_id;
            r_num[0] <= i_data.old_y; r_div[0] <= i_cfg.cell_h;
            r_num[1] <= i_data.old_x; r_div[1] <= i_cfg.cell_w;
            r_num[2] <= i_data.new_y; r_div[2] <= i_cfg.cell_h;
            r_num[3] <= i_data.new_x; r_div[3] <= i_cfg.cell_w;
            for (int k = 0; k < 4; k++) begin
                r_rem[k] <= '0;
                r_quo[k] <= '0;
            end
        end else if (r_busy && r_cnt != 5'd16) begin
            for (int k = 0; k < 4; k++) begin
                r_num[k] <= n_num[k];
                r_rem[k] <= n_rem[k];
                r_quo[k] <= n_quo[k];
            end
        end
        if (r_busy && r_cnt == 5'd16) begin
            r_job.tag  <= r_tag;
            r_job.orow <= w_cell[0];
            r_job.ocol <= w_cell[1];
            r_job.nrow <= w_cell[2];
            r_job.ncol <= w_cell[3];
            if (w_old_off)      r_job.status <= ST_OLD_OFF;
            else if (w_new_off) r_job.status <= ST_NEW_OFF;
            else                r_job.status <= ST_OK;
        end
    end
endmodule
`default_nettype wire

### sv/gnmd_queue.sv
// queue: two-entry job fifo between front and back
`timescale 1ns / 1ps
`default_nettype none
module gnmd_queue (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_valid,
    output logic            o_stall,
    input  gnmd_pkg::t_job  i_job,
    output logic            o_valid,
    input  wire             i_stall,
    output gnmd_pkg::t_job  o_job
);
    import gnmd_pkg::*;

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_stall = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];
    assign w_push  = i_valid && !o_stall;
    assign w_pop   = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_job;
    end
endmodule
`default_nettype wire

### sv/gnmd_back.sv
// back: walks the windows and emits the result beats, taking no new job until the last one's done beat is loaded
`timescale 1ns / 1ps
`default_nettype none
module gnmd_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  gnmd_pkg::t_cfg      i_cfg,
    input  wire                 i_valid,
    output logic                o_stall,
    input  gnmd_pkg::t_job      i_job,
    output logic                o_valid,
    input  wire                 i_stall,
    output gnmd_pkg::t_out_beat o_data
);
    import gnmd_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_LEAVE = 7'b0000010,
        S_ENTER = 7'b0000100,
        S_MOVE  = 7'b0001000,
        S_REM   = 7'b0010000,
        S_ADD   = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state      r_state;
    t_job        r_job;
    logic [15:0] r_or0, r_or1, r_oc0, r_oc1;
    logic [15:0] r_nr0, r_nr1, r_nc0, r_nc1;
    logic [15:0] r_r, r_c;
    logic [31:0] r_rowbase;
    logic        r_ovalid;
    t_out_beat   r_out;
    // row base multiply is registered: the walk idles while each window row's base is loaded
    logic        r_base_ok;

    logic [15:0] w_r0, w_r1, w_c0, w_c1;
    logic        w_in_o, w_in_n, w_emit, w_row_end, w_win_end;
    logic        w_adv;
    logic        w_fire;
    t_kind       w_kind;
    logic [31:0] w_idx;
    logic [16:0] w_tr1, w_tc1;
    logic [16:0] w_tr2, w_tc2;

    // output register frees as soon as its beat is taken
    assign w_adv   = !r_ovalid || !i_stall;
    assign o_valid = r_ovalid;
    assign o_data  = r_out;
    assign o_stall = !(r_state == S_IDLE);

    always_comb begin
        w_r0 = r_or0; w_r1 = r_or1; w_c0 = r_oc0; w_c1 = r_oc1;
        if (r_state != S_LEAVE) begin
            w_r0 = r_nr0; w_r1 = r_nr1; w_c0 = r_nc0; w_c1 = r_nc1;
        end
        w_in_o = r_r >= r_or0 && r_r <= r_or1 && r_c >= r_oc0 && r_c <= r_oc1;
        w_in_n = r_r >= r_nr0 && r_r <= r_nr1 && r_c >= r_nc0 && r_c <= r_nc1;
        unique case (r_state)
            S_LEAVE: w_emit = !w_in_n;
            S_ENTER: w_emit = !w_in_o;
            default: w_emit = 1'b1;
        endcase
        w_row_end = (r_c == w_c1);
        w_win_end = w_row_end && (r_r == w_r1);
        w_idx = r_rowbase + {16'd0, r_c};
        unique case (r_state)
            S_LEAVE: w_kind = KIND_LEAVE;
            S_ENTER: w_kind = KIND_ENTER;
            S_MOVE:  w_kind = KIND_MOVE;
            S_REM:   w_kind = KIND_REMOVE;
            S_ADD:   w_kind = KIND_ADD;
            default: w_kind = KIND_DONE;
        endcase
        // a new beat is loaded into the output register this cycle
        w_fire = w_adv && ((r_state == S_ADD) || (r_state == S_DONE) ||
                 (r_base_ok && w_emit && (r_state == S_LEAVE || r_state == S_ENTER ||
                                          r_state == S_MOVE)));
        w_tr1 = {1'b0, r_job.orow} + 17'(REACH);
        w_tc1 = {1'b0, r_job.ocol} + 17'(REACH);
        w_tr2 = {1'b0, r_job.nrow} + 17'(REACH);
        w_tc2 = {1'b0, r_job.ncol} + 17'(REACH);
    end

    function automatic logic [15:0] f_lo(input logic [15:0] v);
        f_lo = (v >= 16'(REACH)) ? v - 16'(REACH) : 16'd0;
    endfunction

    function automatic logic [15:0] f_hi(input logic [16:0] v, input logic [15:0] n);
        f_hi = (v > {1'b0, n} - 17'd1) ? n - 16'd1 : v[15:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ovalid  <= 1'b0;
            r_base_ok <= 1'b0;
        end else begin
            r_ovalid <= w_fire || (r_ovalid && i_stall);
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_job <= i_job;
                        r_state <= (i_job.status == ST_OK) ? S_REM : S_DONE;
                        r_base_ok <= 1'b0;
                        // S_REM serves here as the window setup step
                    end
                end
                S_LEAVE, S_ENTER, S_MOVE: begin
                    if (!r_base_ok) begin
                        r_rowbase <= 32'(r_r) * 32'(i_cfg.cols);
                        r_base_ok <= 1'b1;
                    end else if (!w_emit || w_adv) begin
                        if (w_emit) begin
                            r_out <= '{r_job.tag, w_kind, w_idx, ST_OK, 1'b0};
                        end
                        if (w_win_end) begin
                            r_base_ok <= 1'b0;
                            r_r <= r_nr0; r_c <= r_nc0;
                            if (r_state == S_LEAVE) r_state <= S_ENTER;
                            else if (r_state == S_ENTER) r_state <= S_MOVE;
                            else if (r_job.orow != r_job.nrow ||
                                     r_job.ocol != r_job.ncol) r_state <= S_ADD;
                            else r_state <= S_DONE;
                            r_rowbase <= 32'(r_job.orow) * 32'(i_cfg.cols);
                        end else if (w_row_end) begin
                            r_base_ok <= 1'b0;
                            r_r <= r_r + 16'd1; r_c <= w_c0;
                        end else begin
                            r_c <= r_c + 16'd1;
                        end
                    end
                end
                S_REM: begin
                    if (!r_base_ok) begin
                        // setup: compute windows
                        r_or0 <= f_lo(r_job.orow); r_or1 <= f_hi(w_tr1, i_cfg.rows);
                        r_oc0 <= f_lo(r_job.ocol); r_oc1 <= f_hi(w_tc1, i_cfg.cols);
                        r_nr0 <= f_lo(r_job.nrow); r_nr1 <= f_hi(w_tr2, i_cfg.rows);
                        r_nc0 <= f_lo(r_job.ncol); r_nc1 <= f_hi(w_tc2, i_cfg.cols);
                        r_r <= f_lo(r_job.orow); r_c <= f_lo(r_job.ocol);
                        r_state <= S_LEAVE;
                    end
                end
                S_ADD: begin
                    // first emit remove (base holds orow*cols), then add
                    if (w_adv) begin
                        if (!r_base_ok) begin
                            r_out <= '{r_job.tag, KIND_REMOVE,
                                       r_rowbase + {16'd0, r_job.ocol}, ST_OK, 1'b0};
                            r_rowbase <= 32'(r_job.nrow) * 32'(i_cfg.cols);
                            r_base_ok <= 1'b1;
                        end else begin
                            r_out <= '{r_job.tag, KIND_ADD,
                                       r_rowbase + {16'd0, r_job.ncol}, ST_OK, 1'b0};
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (w_adv) begin
                        r_out <= '{r_job.tag, KIND_DONE, 32'd0, r_job.status, 1'b1};
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### sv/grid_neighbourhood_move_diff_top.sv
// top level: grid move diff block with config registers, front, queue and back
`timescale 1ns / 1ps
`default_nettype none
// Area-of-interest update for one mover. Each input beat carries a mover's old
// and new position; the block finds both home cells (position / cell size),
// builds the reach-1 windows clipped to the grid and emits result beats: leave
// for cells only in the old window, enter for cells only in the new window,
// move for every new-window cell, then remove-home and add-home when the home
// cell changed, and always a closing done beat (last = 1) with status.
// The front runs four 16-bit restoring dividers in parallel, one quotient bit a
// cycle; a two-entry queue lets it work on the next item while the back drains.
// The back takes the job and runs a setup step, then in each of the leave, enter
// and move walks loads a registered row base for every window row and visits
// every window cell, then emits the home beats and the done beat; an off-grid
// item goes straight to its done beat.
// Configuration is written with i_cfg_we / i_cfg_idx / i_cfg_data and must only
// change while idle.
module grid_neighbourhood_move_diff_top (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_we,
    input  wire [1:0]             i_cfg_idx,
    input  wire [15:0]            i_cfg_data,
    input  wire                   i_valid,
    output logic                  o_stall,
    input  gnmd_pkg::t_in_beat    i_data,
    output logic                  o_valid,
    input  wire                   i_stall,
    output gnmd_pkg::t_out_beat   o_data
);
    import gnmd_pkg::*;

    t_cfg  r_cfg;
    logic  w_fj_valid, w_fj_stall, w_bj_valid, w_bj_stall;
    t_job  w_fj, w_bj;

    // config registers, reset to one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{16'd1, 16'd1, 16'd1, 16'd1};
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_CELL_WIDTH:  r_cfg.cell_w <= i_cfg_data;
                CFG_CELL_HEIGHT: r_cfg.cell_h <= i_cfg_data;
                CFG_GRID_ROWS:   r_cfg.rows   <= i_cfg_data;
                CFG_GRID_COLS:   r_cfg.cols   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    gnmd_front u_front (
        .i_clk, .i_rst_n, .i_cfg(r_cfg),
        .i_valid, .o_stall, .i_data,
        .o_job_valid(w_fj_valid), .i_job_stall(w_fj_stall), .o_job(w_fj)
    );

    gnmd_queue u_queue (
        .i_clk, .i_rst_n,
        .i_valid(w_fj_valid), .o_stall(w_fj_stall), .i_job(w_fj),
        .o_valid(w_bj_valid), .i_stall(w_bj_stall), .o_job(w_bj)
    );

    gnmd_back u_back (
        .i_clk, .i_rst_n, .i_cfg(r_cfg),
        .i_valid(w_bj_valid), .o_stall(w_bj_stall), .i_job(w_bj),
        .o_valid, .i_stall, .o_data
    );
endmodule
`default_nettype wire

### tb/tb_top.sv
// testbench top: drives move beats through the grid move diff block and checks every result
`timescale 1ns / 1ps
`default_nettype none
// Directed moves (grid corners, off-grid old and new cells, zero cell and grid
// sizes, extremes of every field) then random moves under several grid
// settings. A local model works out the result beats of each accepted move;
// the monitor compares every accepted result beat field by field with the
// oldest expected one.
module tb_top;
    import gnmd_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    t_cfg_idx    cfg_idx = CFG_CELL_WIDTH;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    t_in_beat    in_beat = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out_beat   out_beat;

    // local copy of the grid registers
    logic [15:0] m_cell_w = 16'd1, m_cell_h = 16'd1, m_rows = 16'd1, m_cols = 16'd1;

    t_in_beat    pending_moves[$];
    t_out_beat   expected_beats[$];
    int          mismatches = 0;
    int          accepted_moves = 0;
    int          checked_beats = 0;
    int          idle_cycles = 0;
    int          send_idle_pct = 38;
    int          recv_idle_pct = 60;
    bit          stim_done = 1'b0;

    always #4 clk = ~clk;

    grid_neighbourhood_move_diff_top dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .o_stall(in_stall), .i_data(in_beat),
        .o_valid(out_valid), .i_stall(out_stall), .o_data(out_beat)
    );

    function automatic logic [15:0] home_of(logic [15:0] pos, logic [15:0] size);
        if (size == 16'd0) return 16'hFFFF;
        return pos / size;
    endfunction

    function automatic t_out_beat mk_beat(logic [15:0] tag, t_kind k, logic [31:0] idx,
                                          t_status st);
        t_out_beat b;
        b.mover_tag  = tag;
        b.kind       = k;
        b.cell_index = idx;
        b.status     = st;
        b.last       = (k == KIND_DONE);
        return b;
    endfunction

    // expected result beats of one move, appended in emission order
    task automatic predict_move(t_in_beat m);
        logic [31:0] orow, ocol, nrow, ncol;
        logic [31:0] w[2][4];   // [old/new][r0 r1 c0 c1]
        logic [31:0] r, c;
        bit          in_other;
        orow = 32'(home_of(m.old_y, m_cell_h));
        ocol = 32'(home_of(m.old_x, m_cell_w));
        nrow = 32'(home_of(m.new_y, m_cell_h));
        ncol = 32'(home_of(m.new_x, m_cell_w));
        if (orow >= m_rows || ocol >= m_cols) begin
            expected_beats.push_back(mk_beat(m.mover_id, KIND_DONE, 0, ST_OLD_OFF));
            return;
        end
        if (nrow >= m_rows || ncol >= m_cols) begin
            expected_beats.push_back(mk_beat(m.mover_id, KIND_DONE, 0, ST_NEW_OFF));
            return;
        end
        for (int s = 0; s < 2; s++) begin
            r = s ? nrow : orow;
            c = s ? ncol : ocol;
            w[s][0] = (r >= REACH) ? r - REACH : 0;
            w[s][1] = (r + REACH > m_rows - 1) ? m_rows - 1 : r + REACH;
            w[s][2] = (c >= REACH) ? c - REACH : 0;
            w[s][3] = (c + REACH > m_cols - 1) ? m_cols - 1 : c + REACH;
        end
        // pass 0 leave, 1 enter, 2 move
        for (int p = 0; p < 3; p++) begin
            int a, b;
            a = (p == 0) ? 0 : 1;
            b = 1 - a;
            for (r = w[a][0]; r <= w[a][1]; r++)
                for (c = w[a][2]; c <= w[a][3]; c++) begin
                    in_other = r >= w[b][0] && r <= w[b][1] && c >= w[b][2] && c <= w[b][3];
                    if (p == 2 || !in_other)
                        expected_beats.push_back(mk_beat(m.mover_id, t_kind'(p),
                                                         r * m_cols + c, ST_OK));
                end
        end
        if (orow != nrow || ocol != ncol) begin
            expected_beats.push_back(mk_beat(m.mover_id, KIND_REMOVE,
                                             orow * m_cols + ocol, ST_OK));
            expected_beats.push_back(mk_beat(m.mover_id, KIND_ADD,
                                             nrow * m_cols + ncol, ST_OK));
        end
        expected_beats.push_back(mk_beat(m.mover_id, KIND_DONE, 0, ST_OK));
    endtask

    // driver: valid held with a stable payload until accepted
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                predict_move(in_beat);
                accepted_moves++;
            end
            if (!in_valid || !in_stall) begin
                if (pending_moves.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_beat  <= pending_moves.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check accepted result beats and draw receiver stalls
    always @(posedge clk) begin
        t_out_beat want;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                checked_beats++;
                if (expected_beats.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected beat %p", out_beat);
                end else begin
                    want = expected_beats.pop_front();
                    if (out_beat.mover_tag !== want.mover_tag || out_beat.kind !== want.kind
                        || out_beat.cell_index !== want.cell_index
                        || out_beat.status !== want.status || out_beat.last !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p got %p", want, out_beat);
                    end
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // watchdog on cycles with no beat accepted on either side
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("watchdog: no progress, %0d beats still expected", expected_beats.size());
            $display("status: fail");
            $finish;
        end
    end

    task automatic cfg_write(t_cfg_idx idx, logic [15:0] val);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we   <= 1'b0;
        case (idx)
            CFG_CELL_WIDTH:  m_cell_w = val;
            CFG_CELL_HEIGHT: m_cell_h = val;
            CFG_GRID_ROWS:   m_rows = val;
            default:         m_cols = val;
        endcase
    endtask

    task automatic set_grid(logic [15:0] cw, logic [15:0] ch, logic [15:0] rows,
                            logic [15:0] cols);
        cfg_write(CFG_CELL_WIDTH, cw);
        cfg_write(CFG_CELL_HEIGHT, ch);
        cfg_write(CFG_GRID_ROWS, rows);
        cfg_write(CFG_GRID_COLS, cols);
    endtask

    // block until every queued move is accepted and all results have come back
    task automatic drain();
        while (pending_moves.size() > 0 || in_valid || expected_beats.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic add_move(logic [15:0] id, logic [15:0] ox, logic [15:0] oy,
                            logic [15:0] nx, logic [15:0] ny);
        t_in_beat m;
        m.mover_id = id;
        m.old_x = ox;
        m.old_y = oy;
        m.new_x = nx;
        m.new_y = ny;
        pending_moves.push_back(m);
    endtask

    // random moves on the current grid: mostly on-grid short hops, some wild
    task automatic random_moves(int n);
        logic [15:0] ox, oy, nx, ny;
        int          span_x, span_y;
        span_x = (m_cell_w == 0) ? 65535 : m_cell_w * m_cols;
        span_y = (m_cell_h == 0) ? 65535 : m_cell_h * m_rows;
        if (span_x > 65535) span_x = 65535;
        if (span_y > 65535) span_y = 65535;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) < 8) begin
                ox = 16'($urandom_range(span_x - 1));
                oy = 16'($urandom_range(span_y - 1));
                nx = 16'(ox + $urandom_range(4 * m_cell_w) - 2 * m_cell_w);
                ny = 16'(oy + $urandom_range(4 * m_cell_h) - 2 * m_cell_h);
                if ($urandom_range(9) == 0) nx = 16'($urandom_range(span_x - 1));
            end else begin
                ox = 16'($urandom); oy = 16'($urandom);
                nx = 16'($urandom); ny = 16'($urandom);
            end
            add_move(16'($urandom), ox, oy, nx, ny);
        end
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset grid is a single cell: stay, and both off-grid orders
        add_move(16'h0000, 0, 0, 0, 0);
        add_move(16'hFFFF, 1, 0, 0, 0);
        add_move(16'h1234, 0, 0, 0, 65535);
        drain();

        set_grid(16'd10, 16'd10, 16'd8, 16'd8);
        add_move(16'h0001, 0, 0, 0, 0);         // corner stay
        add_move(16'h0002, 0, 0, 79, 79);       // corner to corner
        add_move(16'h0003, 35, 35, 45, 45);     // diagonal hop in the middle
        add_move(16'h0004, 35, 35, 36, 37);     // same cell
        add_move(16'h0005, 35, 35, 55, 35);     // two cells right, windows touch
        add_move(16'h0006, 79, 0, 70, 10);      // edge shuffle
        add_move(16'h0007, 80, 0, 0, 0);        // old off grid
        add_move(16'h0008, 0, 0, 0, 80);        // new off grid
        add_move(16'h0009, 65535, 65535, 65535, 65535);
        add_move(16'h5AA5, 15, 15, 64, 64);
        drain();

        set_grid(16'd0, 16'd3, 16'd4, 16'd4);   // zero cell width: all off grid
        add_move(16'h0010, 0, 0, 0, 0);
        drain();
        set_grid(16'd1, 16'd1, 16'd0, 16'd5);   // zero rows
        add_move(16'h0011, 0, 0, 0, 0);
        drain();
        set_grid(16'd65535, 16'd65535, 16'd65535, 16'd65535);
        add_move(16'h0012, 65535, 65535, 0, 0);
        add_move(16'h0013, 0, 0, 65534, 65534);
        drain();
        set_grid(16'd1, 16'd1, 16'd65535, 16'd65535);
        add_move(16'h0014, 65534, 65534, 65533, 65533);
        add_move(16'h0015, 65535, 65535, 0, 0);
        add_move(16'h0016, 0, 0, 65534, 65534);
        drain();

        // random phases over several grids and idle mixes
        set_grid(16'd7, 16'd5, 16'd6, 16'd9);
        random_moves(120);
        drain();
        send_idle_pct = 60;
        recv_idle_pct = 38;
        set_grid(16'd1, 16'd2, 16'd3, 16'd2);
        random_moves(60);
        drain();
        set_grid(16'd300, 16'd257, 16'd200, 16'd180);
        random_moves(60);
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_grid(16'd1, 16'd1, 16'd65535, 16'd65535);
        random_moves(60);
        drain();
        set_grid(16'd16, 16'd16, 16'd1, 16'd40);
        random_moves(40);
        drain();

        $display("covered %0d moves, %0d result beats checked, %0d mismatches",
                 accepted_moves, checked_beats, mismatches);
        $display("grids: reset, corners, zero sizes, full 16-bit extremes, random mixes");
        if (mismatches == 0 && expected_beats.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
`default_nettype wire
